/* src/fifo_queue_with_delete_top_assert.svh */
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_top_assert.svh
// Assertion macros used by the queue datapath. Expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_DELETE_TOP_ASSERT_SVH
`define FIFO_QUEUE_WITH_DELETE_TOP_ASSERT_SVH

// same-cycle implication
`define FQD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FQD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/fqd_pkg.sv */
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package fqd_pkg;

  localparam int DEPTH  = 16;
  localparam int ITEM_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_ITER = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_ITER = 1'b1
  } state_t;

  typedef struct packed {
    logic             exec;
    logic             iter_step;
    logic [IDX_W-1:0] iter_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic             out_free;
    logic [CNT_W-1:0] count;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/fqd_ctrl.sv */
// ----------------------------------------------------------------------------
// fqd_ctrl
// Command sequencer: accepts beats and walks the queue during iterate.
// ----------------------------------------------------------------------------
`default_nettype none

module fqd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_cmd,
  output logic                   in_ready,
  output fqd_pkg::dp_cmd_t       dp_cmd,
  input  wire fqd_pkg::dp_stat_t dp_stat
);

  fqd_pkg::state_t               state_r, state_nxt;
  logic [fqd_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic                          iter_done;

  assign iter_done = (fqd_pkg::CNT_W'(idx_r) + fqd_pkg::CNT_W'(1)) == dp_stat.count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fqd_pkg::S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    in_ready  = 1'b0;
    dp_cmd    = '0;
    unique case (state_r)
      fqd_pkg::S_IDLE: begin
        in_ready    = dp_stat.out_free;
        dp_cmd.exec = in_valid && dp_stat.out_free;
        if (dp_cmd.exec && (fqd_pkg::cmd_t'(in_cmd) == fqd_pkg::CMD_ITER) &&
            (dp_stat.count > fqd_pkg::CNT_W'(1))) begin
          state_nxt = fqd_pkg::S_ITER;
          idx_nxt   = fqd_pkg::IDX_W'(1);
        end
      end
      fqd_pkg::S_ITER: begin
        dp_cmd.iter_step = dp_stat.out_free;
        dp_cmd.iter_idx  = idx_r;
        if (dp_stat.out_free) begin
          if (iter_done) begin
            state_nxt = fqd_pkg::S_IDLE;
          end else begin
            idx_nxt = idx_r + fqd_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = fqd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/fqd_dp.sv */
// ----------------------------------------------------------------------------
// fqd_dp
// Entry shift file with parallel match, count register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fifo_queue_with_delete_top_assert.svh"

module fqd_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [fqd_pkg::ITEM_W-1:0]  in_item_in,
  input  wire fqd_pkg::dp_cmd_t            dp_cmd,
  output fqd_pkg::dp_stat_t                dp_stat,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [fqd_pkg::ITEM_W-1:0]       out_item_out,
  output logic [fqd_pkg::CNT_W-1:0]        out_count,
  output logic                             out_last
);

  logic [fqd_pkg::ITEM_W-1:0] entries_r   [fqd_pkg::DEPTH];
  logic [fqd_pkg::ITEM_W-1:0] entries_nxt [fqd_pkg::DEPTH];
  logic [fqd_pkg::CNT_W-1:0]  count_r, count_nxt;

  logic                       out_valid_r, out_valid_nxt;
  fqd_pkg::status_t           out_status_r, res_status;
  logic [fqd_pkg::ITEM_W-1:0] out_item_r, res_item;
  logic [fqd_pkg::CNT_W-1:0]  out_count_r;
  logic                       out_last_r, res_last;

  logic [fqd_pkg::DEPTH-1:0]  match_v, prefix_v, shift_v;
  logic                       wr_en, load, out_free;
  fqd_pkg::cmd_t              cmd_v;

  assign cmd_v    = fqd_pkg::cmd_t'(in_cmd);
  assign out_free = !out_valid_r || out_ready;
  assign load     = dp_cmd.exec || dp_cmd.iter_step;

  assign dp_stat.out_free = out_free;
  assign dp_stat.count    = count_r;

  for (genvar g = 0; g < fqd_pkg::DEPTH; g++) begin : g_match
    assign match_v[g]  = (fqd_pkg::CNT_W'(g) < count_r) && (entries_r[g] == in_item_in);
    assign prefix_v[g] = |match_v[g:0];
  end

  always_comb begin
    count_nxt  = count_r;
    res_status = fqd_pkg::ST_OK;
    res_item   = '0;
    res_last   = 1'b1;
    shift_v    = '0;
    wr_en      = 1'b0;
    if (dp_cmd.exec) begin
      unique case (cmd_v)
        fqd_pkg::CMD_ENQ: begin
          if (in_item_in == '0) begin
            res_status = fqd_pkg::ST_NULL;
          end else if (count_r == fqd_pkg::CNT_W'(fqd_pkg::DEPTH)) begin
            res_status = fqd_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + fqd_pkg::CNT_W'(1);
          end
        end
        fqd_pkg::CMD_DEQ: begin
          if (count_r == '0) begin
            res_status = fqd_pkg::ST_EMPTY;
          end else begin
            res_item  = entries_r[0];
            shift_v   = '1;
            count_nxt = count_r - fqd_pkg::CNT_W'(1);
          end
        end
        fqd_pkg::CMD_DEL: begin
          if (|match_v) begin
            shift_v   = prefix_v;
            count_nxt = count_r - fqd_pkg::CNT_W'(1);
          end else begin
            res_status = fqd_pkg::ST_NOTFOUND;
          end
        end
        fqd_pkg::CMD_ITER: begin
          if (count_r == '0) begin
            res_status = fqd_pkg::ST_EMPTY;
          end else begin
            res_item = entries_r[0];
            res_last = (count_r == fqd_pkg::CNT_W'(1));
          end
        end
        default: begin
          res_status = fqd_pkg::ST_OK;
        end
      endcase
    end else if (dp_cmd.iter_step) begin
      res_item = entries_r[dp_cmd.iter_idx];
      res_last = (fqd_pkg::CNT_W'(dp_cmd.iter_idx) + fqd_pkg::CNT_W'(1)) == count_r;
    end
  end

  always_comb begin
    entries_nxt = entries_r;
    for (int i = 0; i < fqd_pkg::DEPTH - 1; i++) begin
      if (shift_v[i]) begin
        entries_nxt[i] = entries_r[i+1];
      end
    end
    if (wr_en) begin
      entries_nxt[count_r[fqd_pkg::IDX_W-1:0]] = in_item_in;
    end
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entries_r <= entries_nxt;
    if (load) begin
      out_status_r <= res_status;
      out_item_r   <= res_item;
      out_count_r  <= count_nxt;
      out_last_r   <= res_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_item_out = out_item_r;
  assign out_count    = out_count_r;
  assign out_last     = out_last_r;

  `FQD_ASSERT_IMP(a_count_bound, 1'b1, count_r <= fqd_pkg::CNT_W'(fqd_pkg::DEPTH), "count overflow")
  `FQD_ASSERT_NXT(a_enq_inc, wr_en, count_r == $past(count_r) + fqd_pkg::CNT_W'(1), "enqueue count")
  `FQD_ASSERT_NXT(a_load_valid, load, out_valid_r, "result beat not registered")

endmodule

`default_nettype wire

/* src/fifo_queue_with_delete_top.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_top
// Bounded queue of item handles with enqueue, dequeue, delete and iterate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries in_cmd and in_item_in; result
//   channel (out_valid/out_ready) carries out_status, out_item_out, out_count
//   and out_last. Every result beat carries the count after the command.
//   Enqueue, dequeue and delete use a 16-way parallel compare and a shift
//   of the entry file; the result beat appears in the output register the cycle
//   after acceptance. A new command is taken every cycle while the output
//   register is empty or being drained and no iterate is running.
//   Iterate of N items gives N beats, one per cycle unless out_ready stalls,
//   the last marked by out_last; in_ready stays low until the final beat is
//   loaded. Empty iterate gives one beat.
//   Reset clears the count and the output valid flag; entry contents are not
//   cleared and no clearing pass is needed.
//   When out_ready is low the result beat holds and in_ready drops until
//   the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_delete_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_cmd,
  input  wire logic [fqd_pkg::ITEM_W-1:0] in_item_in,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [2:0]                      out_status,
  output logic [fqd_pkg::ITEM_W-1:0]      out_item_out,
  output logic [fqd_pkg::CNT_W-1:0]       out_count,
  output logic                            out_last
);

  fqd_pkg::dp_cmd_t  dp_cmd;
  fqd_pkg::dp_stat_t dp_stat;

  fqd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat)
  );

  fqd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_cmd       (in_cmd),
    .in_item_in   (in_item_in),
    .dp_cmd       (dp_cmd),
    .dp_stat      (dp_stat),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_item_out (out_item_out),
    .out_count    (out_count),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire
